// ----- src/flss_pkg.sv -----
// package for the fuzzy line similarity scorer
// types and constants shared by the divider, scan and top-level files; no dependencies
`default_nettype none
package flss_pkg;
  localparam int MaxLenDefault = 1024;
  localparam int ScoreW = 14;
  localparam int IdxW = 16;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChNul = 8'h00;
  localparam logic [7:0] ChUpA = 8'h41;
  localparam logic [7:0] ChUpZ = 8'h5A;
  localparam logic [7:0] CaseBit = 8'h20;
  localparam logic [6:0] Hundred = 7'd100;
  localparam logic [0:0] ActNeedle = 1'b0;
  localparam logic [0:0] ActLine = 1'b1;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic              passes;
    logic [IdxW-1:0]   line_index;
  } result_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    fold_case = (c >= ChUpA && c <= ChUpZ) ? (c ^ CaseBit) : c;
  endfunction

  function automatic logic storable(input logic [7:0] c);
    storable = (c != ChCr) && (c != ChLf) && (c != ChNul);
  endfunction
endpackage
`default_nettype wire

// ----- src/flss_if.sv -----
// request channel interfaces for the scorer
// independent of flss_pkg; the result payload widths are written out directly
`default_nettype none
interface flss_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] char_code;
  logic       last;
  modport source (output valid, action, char_code, last, input ready);
  modport sink (input valid, action, char_code, last, output ready);
endinterface

interface flss_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] score;
  logic        passes;
  logic [15:0] line_index;
  modport source (output valid, score, passes, line_index, input ready);
  modport sink (input valid, score, passes, line_index, output ready);
endinterface
`default_nettype wire

// ----- src/flss_div.sv -----
// restoring divider, one quotient bit per cycle, saturating to score width
// depends on flss_pkg
`default_nettype none
module flss_div #(
  parameter int NumW = 48,
  parameter int DenW = 26
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [NumW-1:0] num,
  input  wire logic [DenW-1:0] den,
  output logic                 done,
  output logic [flss_pkg::ScoreW-1:0] quo
);
  import flss_pkg::*;
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] q_r, q_nxt;
  logic [DenW:0]   rem_r, rem_nxt;
  logic [DenW-1:0] den_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt, done_r, done_nxt;
  logic [DenW:0]   trial;

  // shift one numerator bit into remainder and try subtract
  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[DenW-1:0], q_r[NumW-1]};
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      cnt_nxt = CntW'(NumW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[NumW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[NumW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quo = (q_r > NumW'((1 << ScoreW) - 1)) ? ScoreW'((1 << ScoreW) - 1)
                                                : q_r[ScoreW-1:0];
endmodule
`default_nettype wire

// ----- src/flss_scan.sv -----
// alignment scan over the two character memories
// holds needle and line memories with their write ports and the run scorer; uses flss_pkg
`default_nettype none
module flss_scan #(
  parameter int MaxLen = flss_pkg::MaxLenDefault,
  parameter int LenW = $clog2(MaxLen + 1),
  parameter int AW = $clog2(MaxLen),
  parameter int RawW = 2 * LenW
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_en,
  input  wire logic            wr_sel,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire logic [7:0]      wr_data,
  input  wire logic            start,
  input  wire logic [LenW-1:0] needle_len,
  input  wire logic [LenW-1:0] line_len,
  output logic                 done,
  output logic [RawW-1:0]      raw,
  output logic [LenW-1:0]      short_len,
  output logic [LenW-1:0]      long_len
);
  import flss_pkg::*;

  logic [7:0] needle_mem [MaxLen];
  logic [7:0] line_mem [MaxLen];
  logic [7:0] nd_q, ln_q;

  logic [LenW-1:0] i_r, i_nxt, j_r, j_nxt, sl_r, ll_r;
  logic            swap_r, busy_r, busy_nxt, vld_r, vld_nxt, done_r, done_nxt;
  logic            jend_r, jend_nxt, fin_r, fin_nxt;
  logic [1:0]      run_r, run_nxt;
  logic [RawW-1:0] raw_r, raw_nxt;
  logic [LenW-1:0] sidx, lidx;
  logic [AW-1:0]   n_addr, l_addr;
  logic            eq;

  // addresses: short string at j, long string at i+j
  always_comb begin
    sidx = j_r;
    lidx = i_r + j_r;
    n_addr = swap_r ? lidx[AW-1:0] : sidx[AW-1:0];
    l_addr = swap_r ? sidx[AW-1:0] : lidx[AW-1:0];
    if (wr_en && !wr_sel) n_addr = wr_addr;
    if (wr_en && wr_sel) l_addr = wr_addr;
  end

  // memories with registered read
  always_ff @(posedge clk) begin
    if (wr_en && !wr_sel) needle_mem[n_addr] <= wr_data;
    nd_q <= needle_mem[n_addr];
    if (wr_en && wr_sel) line_mem[l_addr] <= wr_data;
    ln_q <= line_mem[l_addr];
  end

  assign eq = (nd_q == ln_q);

  // sequence alignments and score runs on returned data
  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    busy_nxt = busy_r;
    vld_nxt = 1'b0;
    jend_nxt = 1'b0;
    fin_nxt = 1'b0;
    done_nxt = 1'b0;
    run_nxt = run_r;
    raw_nxt = raw_r;
    if (vld_r) begin
      if (eq) begin
        if (run_r == 2'd1) begin
          raw_nxt = raw_r + RawW'(2);
          run_nxt = 2'd2;
        end else if (run_r == 2'd2) begin
          raw_nxt = raw_r + RawW'(1);
        end else begin
          run_nxt = 2'd1;
        end
      end else begin
        run_nxt = 2'd0;
      end
      if (jend_r) run_nxt = 2'd0;
      if (fin_r) done_nxt = 1'b1;
    end
    if (start) begin
      i_nxt = '0;
      j_nxt = '0;
      raw_nxt = '0;
      run_nxt = 2'd0;
      busy_nxt = (needle_len != '0) && (line_len != '0);
      done_nxt = !busy_nxt;
    end else if (busy_r) begin
      vld_nxt = 1'b1;
      if (j_r == sl_r - 1'b1) begin
        jend_nxt = 1'b1;
        j_nxt = '0;
        if (i_r + sl_r == ll_r) begin
          fin_nxt = 1'b1;
          busy_nxt = 1'b0;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end else begin
        j_nxt = j_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      vld_r <= 1'b0;
      done_r <= 1'b0;
      jend_r <= 1'b0;
      fin_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      vld_r <= vld_nxt;
      done_r <= done_nxt;
      jend_r <= jend_nxt;
      fin_r <= fin_nxt;
    end
    i_r <= i_nxt;
    j_r <= j_nxt;
    run_r <= run_nxt;
    raw_r <= raw_nxt;
    if (start) begin
      swap_r <= needle_len > line_len;
      sl_r <= (needle_len > line_len) ? line_len : needle_len;
      ll_r <= (needle_len > line_len) ? needle_len : line_len;
    end
  end

  assign done = done_r;
  assign raw = raw_r;
  assign short_len = sl_r;
  assign long_len = ll_r;
endmodule
`default_nettype wire

// ----- src/fuzzy_line_similarity_scorer_unit.sv -----
// Fuzzy line similarity scorer, top level.
// Input channel in_*: one character request per cycle while ready; action 0
// loads needle characters, action 1 loads haystack line characters, last
// ends the string. Characters are lowercased and CR, LF and NUL are not
// stored; strings past MAX_LEN characters are truncated.
// Output channel out_*: one result request per completed haystack line with
// score, passes flag and line index.
// Throughput: one character per cycle while loading. After a line's last
// character the alignment scan reads both memories once per compared pair,
// (long-short+1)*short pairs, then the bit-serial divider works through the
// NumW-bit numerator (NumW = 3*LenW+7, 40 at the default MAX_LEN). Input is
// stalled from the last character until the result is registered for output.
// Reset: lengths and line counter clear, needle is empty and complete,
// threshold is 0. Memory contents are not cleared.
// Stall: the result waits in the output register while out_ready is low;
// characters keep loading meanwhile, and a further line end holds the block
// after its divide until the waiting result is taken.
// cfg_we/cfg_wdata write pass_threshold; write it only while the block is idle (not enforced by the block).
`default_nettype none
module fuzzy_line_similarity_scorer_unit #(
  parameter int MaxLen = flss_pkg::MaxLenDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  flss_in_if.sink          in_ch,
  flss_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [13:0] cfg_wdata
);
  import flss_pkg::*;
  localparam int LenW = $clog2(MaxLen + 1);
  localparam int RawW = 2 * LenW;
  localparam int NumW = RawW + LenW + 7;
  localparam int DenW = 2 * LenW;
  localparam int AW = $clog2(MaxLen);

  localparam logic [1:0] StLoad = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDiv = 2'd2;
  localparam logic [1:0] StOut = 2'd3;

  logic [1:0]      st_r, st_nxt;
  logic [ScoreW-1:0] thr_r;
  logic [LenW-1:0] nlen_r, nlen_nxt, llen_r, llen_nxt;
  logic [IdxW-1:0] cnt_r, cnt_nxt;
  logic            ndone_r, ndone_nxt;
  logic            acc, store, wr_en, scan_start, scan_done, div_done, div_start;
  logic [AW-1:0]   wr_addr;
  logic [7:0]      wr_data;
  logic [RawW-1:0] raw;
  logic [LenW-1:0] sl, ll;
  logic [RawW+LenW-1:0] rs;
  logic [NumW-1:0] prod_r;
  logic [DenW-1:0] den_r;
  logic [ScoreW-1:0] quo;
  logic            zero_r;
  result_t         res_r;
  logic            ov_r, ov_nxt;
  logic            dv_r, dv_nxt, fin_div;

  assign in_ch.ready = (st_r == StLoad);
  assign acc = in_ch.valid && in_ch.ready;
  assign store = storable(in_ch.char_code);
  assign wr_data = fold_case(in_ch.char_code);

  // character load and string bookkeeping
  always_comb begin
    nlen_nxt = nlen_r;
    llen_nxt = llen_r;
    cnt_nxt = cnt_r;
    ndone_nxt = ndone_r;
    wr_en = 1'b0;
    wr_addr = '0;
    scan_start = 1'b0;
    if (acc) begin
      if (in_ch.action == ActNeedle) begin
        if (ndone_r) begin
          nlen_nxt = '0;
          llen_nxt = '0;
          cnt_nxt = '0;
          ndone_nxt = 1'b0;
        end
        wr_addr = ndone_r ? '0 : nlen_r[AW-1:0];
        if (store && (ndone_r || nlen_r < LenW'(MaxLen))) begin
          wr_en = 1'b1;
          nlen_nxt = (ndone_r ? '0 : nlen_r) + 1'b1;
        end
        if (in_ch.last) begin
          ndone_nxt = 1'b1;
          llen_nxt = '0;
          cnt_nxt = '0;
        end
      end else begin
        wr_addr = llen_r[AW-1:0];
        if (store && llen_r < LenW'(MaxLen)) begin
          wr_en = 1'b1;
          llen_nxt = llen_r + 1'b1;
        end
        scan_start = in_ch.last;
      end
    end
  end

  flss_scan #(.MaxLen(MaxLen), .LenW(LenW), .AW(AW), .RawW(RawW)) u_scan (
    .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_sel(in_ch.action),
    .wr_addr(wr_addr), .wr_data(wr_data), .start(scan_start),
    .needle_len(nlen_nxt), .line_len(llen_nxt), .done(scan_done),
    .raw(raw), .short_len(sl), .long_len(ll)
  );

  flss_div #(.NumW(NumW), .DenW(DenW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(prod_r), .den(den_r),
    .done(div_done), .quo(quo)
  );

  // divide finished and output register free or being emptied
  assign fin_div = (st_r == StDiv) && (div_done || dv_r) && (!ov_r || out_ch.ready);

  // raw score times short length
  assign rs = (RawW+LenW)'(raw) * (RawW+LenW)'(sl);

  // control sequence
  always_comb begin
    st_nxt = st_r;
    div_start = 1'b0;
    ov_nxt = ov_r;
    dv_nxt = dv_r;
    if (out_ch.ready) ov_nxt = 1'b0;
    case (st_r)
      StLoad: if (scan_start) st_nxt = StScan;
      StScan: if (scan_done) st_nxt = StOut;
      StOut: begin
        div_start = 1'b1;
        st_nxt = StDiv;
      end
      StDiv: begin
        if (div_done) dv_nxt = 1'b1;
        if (fin_div) begin
          st_nxt = StLoad;
          ov_nxt = 1'b1;
          dv_nxt = 1'b0;
        end
      end
      default: st_nxt = StLoad;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StLoad;
      thr_r <= '0;
      nlen_r <= '0;
      llen_r <= '0;
      cnt_r <= '0;
      ndone_r <= 1'b1;
      ov_r <= 1'b0;
      dv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) thr_r <= cfg_wdata;
      nlen_r <= nlen_nxt;
      llen_r <= fin_div ? '0 : llen_nxt;
      cnt_r <= fin_div ? cnt_r + 1'b1 : cnt_nxt;
      ndone_r <= ndone_nxt;
      ov_r <= ov_nxt;
      dv_r <= dv_nxt;
    end
    // scale terms after scan
    if (st_r == StScan && scan_done) begin
      prod_r <= NumW'(rs) * NumW'(Hundred);
      den_r <= DenW'(ll) * DenW'(ll);
      zero_r <= (sl == '0);
    end
    if (fin_div) begin
      res_r.score <= zero_r ? '0 : quo;
      res_r.passes <= (zero_r ? '0 : quo) >= thr_r;
      res_r.line_index <= cnt_r;
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.score = res_r.score;
  assign out_ch.passes = res_r.passes;
  assign out_ch.line_index = res_r.line_index;
endmodule
`default_nettype wire
